FILE: rtl/wtr_pkg.sv
// package for the water region table
// op codes, controller states and fixed-point constants; no dependencies

package wtr_pkg;

    // op codes of an input word
    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_DRAIN  = 3'd1,
        OP_TICK   = 3'd2,
        OP_QUERY3 = 3'd3,
        OP_QUERY2 = 3'd4
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DRAIN_RD,
        ST_DRAIN_WR,
        ST_SCAN
    } state_t;

    // fall rate is unsigned q8.16, frame time unsigned q0.16
    localparam int RATE_BITS  = 24;
    localparam int FT_BITS    = 16;
    localparam int RATE_SHIFT = 24;
    localparam int FALL_ACCEL = 5;

    // 3.0 in q.8
    localparam int HEIGHT_MARGIN = 768;

    // slot fields on the ports
    localparam int SLOT_BITS = 4;

    // about 1/60 s
    localparam logic [FT_BITS-1:0] FT_RESET = 16'd1092;

endpackage

FILE: rtl/wtr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module wtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [WIDTH-1:0]   wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [WIDTH-1:0]   rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/water_region_table.sv
// water region table top level: controller, scan pipeline and region memory
// depends on wtr_pkg and wtr_ram
//
//  channel   | signals                                    | handshake
//  ----------+--------------------------------------------+-------------------------
//  command   | op slot min_x max_x min_z max_z top_y      | taken when start & !busy
//            | goal_drop pos_x pos_y pos_z radius         |
//  result    | hit hit_slot water_level refresh rejected  | one cycle, marked by done
//  config    | cfg_data (frame_time)                      | cfg_valid & cfg_ready
//
// tick and both queries stream the region memory through its single read port,
// one slot a cycle, into a three-stage pipeline.
// add walks the valid bits one slot a cycle.
// start draining reads the entry, then writes it back; a refused drain and other op codes answer from idle.
// reset clears the valid and draining bits at once; no clearing pass is needed.
// the result is shown for exactly one cycle; the receiver cannot stall it.

module water_region_table #(
    parameter int MAX_REGIONS = 16,
    parameter int COORD_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          op,
    input  logic [wtr_pkg::SLOT_BITS-1:0]       slot,
    input  logic signed [COORD_BITS-1:0]        min_x,
    input  logic signed [COORD_BITS-1:0]        max_x,
    input  logic signed [COORD_BITS-1:0]        min_z,
    input  logic signed [COORD_BITS-1:0]        max_z,
    input  logic signed [COORD_BITS-1:0]        top_y,
    input  logic signed [COORD_BITS-1:0]        goal_drop,
    input  logic signed [COORD_BITS-1:0]        pos_x,
    input  logic signed [COORD_BITS-1:0]        pos_y,
    input  logic signed [COORD_BITS-1:0]        pos_z,
    input  logic [COORD_BITS-2:0]               radius,
    // result channel
    output logic                                done,
    output logic                                hit,
    output logic [wtr_pkg::SLOT_BITS-1:0]       hit_slot,
    output logic signed [COORD_BITS:0]          water_level,
    output logic                                refresh,
    output logic                                rejected,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wtr_pkg::FT_BITS-1:0]         cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int RB = wtr_pkg::RATE_BITS;
    localparam int FB = wtr_pkg::FT_BITS;
    localparam int PB = RB + FB;
    localparam int DB = PB - wtr_pkg::RATE_SHIFT;
    localparam int SB = wtr_pkg::SLOT_BITS;

    localparam logic [RB-1:0] RATE_MAX = {RB{1'b1}};
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_REGIONS - 1);
    localparam logic [CW-1:0] N_SLOTS  = CW'(MAX_REGIONS);

    // one region entry in memory
    typedef struct packed {
        logic signed [CB-1:0] lo_x;
        logic signed [CB-1:0] hi_x;
        logic signed [CB-1:0] lo_z;
        logic signed [CB-1:0] hi_z;
        logic signed [CB-1:0] top;
        logic signed [CB-1:0] drop;
        logic signed [CB-1:0] goal;
        logic [RB-1:0]        rate;
    } entry_t;

    localparam int EW = $bits(entry_t);

    // sign-extend a coordinate by one bit
    function automatic logic signed [CB:0] ext1(input logic [CB-1:0] v);
        return $signed({v[CB-1], v});
    endfunction

    // sphere interval against box interval on one axis
    function automatic logic axis_ok(input logic signed [CB:0] lo,
                                     input logic signed [CB:0] hi,
                                     input logic signed [CB:0] blo,
                                     input logic signed [CB:0] bhi);
        return (bhi >= lo) && (hi >= blo) &&
               (((lo <= blo) && (blo <= hi)) || ((blo <= lo) && (lo <= bhi)));
    endfunction

    // controller and configuration
    wtr_pkg::state_t       state_reg, state_next;
    logic [FB-1:0]         frame_time_reg;
    logic [MAX_REGIONS-1:0] valid_reg;
    logic [MAX_REGIONS-1:0] drain_reg;

    // captured command word
    logic [2:0]            op_reg;
    logic [IW-1:0]         slot_idx_reg;
    entry_t                add_ent_reg;
    logic signed [CB-1:0]  goal_reg;
    logic signed [CB:0]    qlo_x_reg, qhi_x_reg, qlo_z_reg, qhi_z_reg;
    logic signed [CB-1:0]  py_reg;

    // add walk and scan issue counters
    logic [IW-1:0]         idx_reg;
    logic [CW-1:0]         issue_reg;

    // scan pipeline
    logic                  s1_vld_reg, s1_live_reg;
    logic [IW-1:0]         s1_idx_reg;
    logic                  s2_vld_reg, s2_live_reg;
    logic [IW-1:0]         s2_idx_reg;
    entry_t                s2_ent_reg;
    logic [PB-1:0]         s2_prod_reg;
    logic [RB-1:0]         s2_rate_reg;
    logic signed [CB:0]    s2_lv_reg;
    logic [1:0]            s2_axes_reg;
    logic                  s3_vld_reg, s3_live_reg;
    logic [IW-1:0]         s3_idx_reg;
    entry_t                s3_ent_reg;
    logic [DB-1:0]         s3_dec_reg;
    logic [RB-1:0]         s3_rate_reg;
    logic signed [CB:0]    s3_lv_reg;
    logic                  s3_qhit_reg;

    // scan accumulators
    logic                  found_reg;
    logic [IW-1:0]         found_idx_reg;
    logic signed [CB:0]    found_lv_reg;
    logic                  refresh_acc_reg;

    // result registers
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    logic [SB-1:0]         hit_slot_reg, hit_slot_next;
    logic signed [CB:0]    level_reg, level_next;
    logic                  refresh_reg, refresh_next;
    logic                  rejected_reg, rejected_next;

    // memory ports
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    entry_t                wr_ent;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [EW-1:0]         rd_data;
    entry_t                rd_ent;

    logic                  accept;
    logic                  issuing;
    logic [IW-1:0]         slot_in_idx;
    logic                  drain_bad;

    // s1 arithmetic
    logic [PB-1:0]         s1_prod;
    logic [RB:0]           s1_rate_sum;
    logic signed [CB:0]    s1_lv;

    // s2 arithmetic
    logic [PB-1:0]         s2_round;
    logic signed [CB+1:0]  s2_lim;
    logic signed [CB+1:0]  s2_py;
    logic                  s2_qhit;

    // s3 arithmetic
    logic signed [CB+1:0]  s3_d;
    logic signed [CB+1:0]  s3_d_sat;
    logic signed [CB+1:0]  s3_cmin;
    logic                  s3_fin;
    logic                  tick_wr;
    logic                  tick_fin;
    logic                  s3_last;
    entry_t                tick_ent;

    // region memory
    wtr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_REGIONS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_ent = rd_data;

    assign busy      = (state_reg != wtr_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign slot_in_idx = IW'(slot);
    assign drain_bad   = (int'(slot) >= MAX_REGIONS) || !valid_reg[slot_in_idx] ||
                         drain_reg[slot_in_idx];

    assign issuing = (state_reg == wtr_pkg::ST_SCAN) && (issue_reg < N_SLOTS);

    // s1: fall rate product, rate update, level and axis tests
    assign s1_prod     = PB'(rd_ent.rate) * PB'(frame_time_reg);
    assign s1_rate_sum = (RB+1)'(rd_ent.rate) +
                         (RB+1)'(frame_time_reg) * (RB+1)'(wtr_pkg::FALL_ACCEL);
    assign s1_lv       = ext1(rd_ent.top) + ext1(rd_ent.drop);

    // s2: rounding of the drop step and the height test
    assign s2_round = s2_prod_reg + (PB'(1) << (wtr_pkg::RATE_SHIFT - 1));
    assign s2_lim   = $signed({s2_lv_reg[CB], s2_lv_reg}) -
                      $signed((CB+2)'(wtr_pkg::HEIGHT_MARGIN));
    assign s2_py    = $signed({{2{py_reg[CB-1]}}, py_reg});
    assign s2_qhit  = s2_live_reg && (&s2_axes_reg) &&
                      ((op_reg == wtr_pkg::OP_QUERY2) || (s2_py <= s2_lim));

    // s3: new drop, saturation and goal test
    assign s3_cmin  = $signed({3'b111, {(CB-1){1'b0}}});
    assign s3_d     = $signed({{2{s3_ent_reg.drop[CB-1]}}, s3_ent_reg.drop}) -
                      $signed({{(CB+2-DB){1'b0}}, s3_dec_reg});
    assign s3_d_sat = (s3_d < s3_cmin) ? s3_cmin : s3_d;
    assign s3_fin   = s3_d_sat <= $signed({{2{s3_ent_reg.goal[CB-1]}}, s3_ent_reg.goal});
    assign tick_wr  = s3_vld_reg && s3_live_reg && (op_reg == wtr_pkg::OP_TICK);
    assign tick_fin = tick_wr && s3_fin;
    assign s3_last  = s3_vld_reg && (s3_idx_reg == LAST_IDX);

    always_comb
    begin
        tick_ent      = s3_ent_reg;
        tick_ent.drop = s3_fin ? s3_ent_reg.goal : s3_d_sat[CB-1:0];
        tick_ent.rate = s3_rate_reg;
    end

    // next state, memory access and result
    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        hit_next      = 1'b0;
        hit_slot_next = '0;
        level_next    = '0;
        refresh_next  = 1'b0;
        rejected_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_ent        = add_ent_reg;
        rd_en         = 1'b0;
        rd_addr       = issue_reg[IW-1:0];

        unique case (state_reg)
            wtr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        wtr_pkg::OP_ADD:
                        begin
                            state_next = wtr_pkg::ST_ADD;
                        end
                        wtr_pkg::OP_DRAIN:
                        begin
                            if (drain_bad)
                            begin
                                done_next     = 1'b1;
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                state_next = wtr_pkg::ST_DRAIN_RD;
                            end
                        end
                        wtr_pkg::OP_TICK, wtr_pkg::OP_QUERY3, wtr_pkg::OP_QUERY2:
                        begin
                            state_next = wtr_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            wtr_pkg::ST_ADD:
            begin
                if (!valid_reg[idx_reg])
                begin
                    wr_en         = 1'b1;
                    done_next     = 1'b1;
                    hit_slot_next = SB'(idx_reg);
                    state_next    = wtr_pkg::ST_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    done_next     = 1'b1;
                    rejected_next = 1'b1;
                    state_next    = wtr_pkg::ST_IDLE;
                end
            end
            wtr_pkg::ST_DRAIN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = slot_idx_reg;
                state_next = wtr_pkg::ST_DRAIN_WR;
            end
            wtr_pkg::ST_DRAIN_WR:
            begin
                wr_en       = 1'b1;
                wr_addr     = slot_idx_reg;
                wr_ent      = rd_ent;
                wr_ent.goal = goal_reg;
                wr_ent.rate = '0;
                done_next   = 1'b1;
                state_next  = wtr_pkg::ST_IDLE;
            end
            wtr_pkg::ST_SCAN:
            begin
                rd_en   = issuing;
                wr_en   = tick_wr;
                wr_addr = s3_idx_reg;
                wr_ent  = tick_ent;
                if (s3_last)
                begin
                    done_next  = 1'b1;
                    state_next = wtr_pkg::ST_IDLE;
                    if (op_reg == wtr_pkg::OP_TICK)
                    begin
                        refresh_next = refresh_acc_reg || tick_fin;
                    end
                    else if (found_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = SB'(found_idx_reg);
                        level_next    = found_lv_reg;
                    end
                    else if (s3_qhit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = SB'(s3_idx_reg);
                        level_next    = s3_lv_reg;
                    end
                end
            end
            default:
            begin
                state_next = wtr_pkg::ST_IDLE;
            end
        endcase
    end

    // state, configuration and region flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wtr_pkg::ST_IDLE;
            frame_time_reg <= wtr_pkg::FT_RESET;
            valid_reg      <= '0;
            drain_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                frame_time_reg <= cfg_data;
            end
            if ((state_reg == wtr_pkg::ST_ADD) && !valid_reg[idx_reg])
            begin
                valid_reg[idx_reg] <= 1'b1;
                drain_reg[idx_reg] <= 1'b0;
            end
            if (state_reg == wtr_pkg::ST_DRAIN_WR)
            begin
                drain_reg[slot_idx_reg] <= 1'b1;
            end
            if (tick_fin)
            begin
                valid_reg[s3_idx_reg] <= 1'b0;
                drain_reg[s3_idx_reg] <= 1'b0;
            end
        end
    end

    // capture of the command word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg           <= op;
            slot_idx_reg     <= slot_in_idx;
            add_ent_reg.lo_x <= min_x;
            add_ent_reg.hi_x <= max_x;
            add_ent_reg.lo_z <= min_z;
            add_ent_reg.hi_z <= max_z;
            add_ent_reg.top  <= top_y;
            add_ent_reg.drop <= '0;
            add_ent_reg.goal <= '0;
            add_ent_reg.rate <= '0;
            goal_reg         <= goal_drop;
            qlo_x_reg        <= ext1(pos_x) - $signed({2'b00, radius});
            qhi_x_reg        <= ext1(pos_x) + $signed({2'b00, radius});
            qlo_z_reg        <= ext1(pos_z) - $signed({2'b00, radius});
            qhi_z_reg        <= ext1(pos_z) + $signed({2'b00, radius});
            py_reg           <= pos_y;
        end
    end

    // add walk and scan issue counters, pipeline valid flags, accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            issue_reg       <= '0;
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            s3_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            refresh_acc_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                idx_reg         <= '0;
                issue_reg       <= '0;
                found_reg       <= 1'b0;
                refresh_acc_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == wtr_pkg::ST_ADD)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (issuing)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
                if (s3_vld_reg && s3_qhit_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (tick_fin)
                begin
                    refresh_acc_reg <= 1'b1;
                end
            end
            s1_vld_reg <= issuing;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // scan pipeline payload
    always_ff @(posedge clk)
    begin
        if (issuing)
        begin
            s1_idx_reg  <= issue_reg[IW-1:0];
            s1_live_reg <= valid_reg[issue_reg[IW-1:0]] &&
                           ((op_reg != wtr_pkg::OP_TICK) || drain_reg[issue_reg[IW-1:0]]);
        end
        s2_idx_reg  <= s1_idx_reg;
        s2_live_reg <= s1_live_reg;
        s2_ent_reg  <= rd_ent;
        s2_prod_reg <= s1_prod;
        s2_rate_reg <= s1_rate_sum[RB] ? RATE_MAX : s1_rate_sum[RB-1:0];
        s2_lv_reg   <= s1_lv;
        s2_axes_reg <= {axis_ok(qlo_x_reg, qhi_x_reg, ext1(rd_ent.lo_x), ext1(rd_ent.hi_x)),
                        axis_ok(qlo_z_reg, qhi_z_reg, ext1(rd_ent.lo_z), ext1(rd_ent.hi_z))};
        s3_idx_reg  <= s2_idx_reg;
        s3_live_reg <= s2_live_reg;
        s3_ent_reg  <= s2_ent_reg;
        s3_dec_reg  <= s2_round[PB-1:wtr_pkg::RATE_SHIFT];
        s3_rate_reg <= s2_rate_reg;
        s3_lv_reg   <= s2_lv_reg;
        s3_qhit_reg <= s2_qhit;
        if (s3_vld_reg && s3_qhit_reg && !found_reg)
        begin
            found_idx_reg <= s3_idx_reg;
            found_lv_reg  <= s3_lv_reg;
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        level_reg    <= level_next;
        refresh_reg  <= refresh_next;
        rejected_reg <= rejected_next;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign hit_slot    = hit_slot_reg;
    assign water_level = level_reg;
    assign refresh     = refresh_reg;
    assign rejected    = rejected_reg;

    // a slot never drains without being present
    assert property (@(posedge clk) disable iff (!rst_n)
        (drain_reg & ~valid_reg) == '0)
    else $error("draining flag set on an absent region");

    // memory writes only come from an operation in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wtr_pkg::ST_IDLE) |-> !wr_en)
    else $error("region memory written while idle");

    // a hit only comes out of a query
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |->
            ((op_reg == wtr_pkg::OP_QUERY3) || (op_reg == wtr_pkg::OP_QUERY2)))
    else $error("hit reported for an operation that is not a query");

    // pipeline words are only launched by a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> $past(state_reg == wtr_pkg::ST_SCAN))
    else $error("scan pipeline word outside a scan");

endmodule

FILE: tb/sv/tb_water_region_table.sv
// testbench for water_region_table: directed words, then random words in phases
// checks every result word against a built-in region table predictor, or against its pinned answer
// depends on wtr_pkg and the water_region_table rtl

module tb_water_region_table;

    localparam int REGIONS      = 16;
    localparam int CB           = 24;
    localparam int SB           = wtr_pkg::SLOT_BITS;
    localparam int FB           = wtr_pkg::FT_BITS;
    localparam int DRAIN_CYCLES = REGIONS + 8;
    localparam int PHASE_WORDS  = 250;

    // op codes the block ignores
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-2:0]        R_MAX = {(CB-1){1'b1}};
    localparam longint COORD_LO = -(longint'(1) << (CB-1));
    localparam longint COORD_HI = (longint'(1) << (CB-1)) - 1;
    localparam longint RATE_TOP = (longint'(1) << wtr_pkg::RATE_BITS) - 1;

    typedef struct packed {
        logic                 hit;
        logic [SB-1:0]        slot;
        logic signed [CB:0]   level;
        logic                 refresh;
        logic                 rejected;
    } region_answer_t;

    typedef struct packed {
        logic [2:0]           op;
        logic [SB-1:0]        slot;
        logic signed [CB-1:0] min_x;
        logic signed [CB-1:0] max_x;
        logic signed [CB-1:0] min_z;
        logic signed [CB-1:0] max_z;
        logic signed [CB-1:0] top_y;
        logic signed [CB-1:0] goal_drop;
        logic signed [CB-1:0] pos_x;
        logic signed [CB-1:0] pos_y;
        logic signed [CB-1:0] pos_z;
        logic [CB-2:0]        radius;
        logic                 pinned;
        region_answer_t       want;
    } word_t;

    localparam region_answer_t QUIET   = '0;
    // rejected is the lowest bit of the answer
    localparam region_answer_t REFUSED = 32'd1;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           op;
    logic [SB-1:0]        slot;
    logic signed [CB-1:0] min_x;
    logic signed [CB-1:0] max_x;
    logic signed [CB-1:0] min_z;
    logic signed [CB-1:0] max_z;
    logic signed [CB-1:0] top_y;
    logic signed [CB-1:0] goal_drop;
    logic signed [CB-1:0] pos_x;
    logic signed [CB-1:0] pos_y;
    logic signed [CB-1:0] pos_z;
    logic [CB-2:0]        radius;
    logic                 done;
    logic                 hit;
    logic [SB-1:0]        hit_slot;
    logic signed [CB:0]   water_level;
    logic                 refresh;
    logic                 rejected;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [FB-1:0]        cfg_data;

    // predictor copy of the region table
    logic                 rg_live  [REGIONS];
    logic                 rg_drain [REGIONS];
    logic signed [CB-1:0] rg_lo_x  [REGIONS];
    logic signed [CB-1:0] rg_hi_x  [REGIONS];
    logic signed [CB-1:0] rg_lo_z  [REGIONS];
    logic signed [CB-1:0] rg_hi_z  [REGIONS];
    logic signed [CB-1:0] rg_top   [REGIONS];
    logic signed [CB-1:0] rg_drop  [REGIONS];
    logic signed [CB-1:0] rg_goal  [REGIONS];
    logic [wtr_pkg::RATE_BITS-1:0] rg_rate [REGIONS];
    logic [FB-1:0]        ft_now;

    region_answer_t answers_due [$];
    region_answer_t pin_ans;
    region_answer_t got;
    region_answer_t want;
    region_answer_t ans;
    logic           pin_valid;
    int             words_taken;
    int             cfg_taken;
    int             fails;
    word_t          script [$];

    water_region_table #(
        .MAX_REGIONS (REGIONS),
        .COORD_BITS  (CB)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .slot        (slot),
        .min_x       (min_x),
        .max_x       (max_x),
        .min_z       (min_z),
        .max_z       (max_z),
        .top_y       (top_y),
        .goal_drop   (goal_drop),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .radius      (radius),
        .done        (done),
        .hit         (hit),
        .hit_slot    (hit_slot),
        .water_level (water_level),
        .refresh     (refresh),
        .rejected    (rejected),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("water_region_table: mismatch");
        $finish;
    end

    // sphere interval against one box axis, inverted boxes included
    function automatic bit axis_overlaps(longint lo, longint hi, longint blo, longint bhi);
        if (bhi < lo || hi < blo)
            return 1'b0;
        return (lo <= blo && blo <= hi) || (blo <= lo && lo <= bhi);
    endfunction

    // apply the driven word to the table copy and work out its answer
    task automatic apply_region_op(output region_answer_t a);
        int     i;
        int     free_slot;
        longint prod;
        longint dec;
        longint d;
        longint nrate;
        longint px;
        longint py;
        longint pz;
        longint r;
        longint lv;
        a = '0;
        case (op)
            wtr_pkg::OP_ADD:
            begin
                free_slot = -1;
                for (i = 0; i < REGIONS; i++)
                begin
                    if (!rg_live[i])
                    begin
                        free_slot = i;
                        break;
                    end
                end
                if (free_slot < 0)
                    a.rejected = 1'b1;
                else
                begin
                    rg_live[free_slot]  = 1'b1;
                    rg_drain[free_slot] = 1'b0;
                    rg_lo_x[free_slot]  = min_x;
                    rg_hi_x[free_slot]  = max_x;
                    rg_lo_z[free_slot]  = min_z;
                    rg_hi_z[free_slot]  = max_z;
                    rg_top[free_slot]   = top_y;
                    rg_drop[free_slot]  = '0;
                    rg_goal[free_slot]  = '0;
                    rg_rate[free_slot]  = '0;
                    a.slot = SB'(free_slot);
                end
            end
            wtr_pkg::OP_DRAIN:
            begin
                if (!rg_live[slot] || rg_drain[slot])
                    a.rejected = 1'b1;
                else
                begin
                    rg_goal[slot]  = goal_drop;
                    rg_rate[slot]  = '0;
                    rg_drain[slot] = 1'b1;
                end
            end
            wtr_pkg::OP_TICK:
            begin
                for (i = 0; i < REGIONS; i++)
                begin
                    if (!rg_live[i] || !rg_drain[i])
                        continue;
                    // drop by rate * frame time, rounded half up
                    prod = longint'(rg_rate[i]) * longint'(ft_now);
                    dec  = (prod + (longint'(1) << (wtr_pkg::RATE_SHIFT - 1)))
                           >> wtr_pkg::RATE_SHIFT;
                    d    = longint'(rg_drop[i]) - dec;
                    if (d < COORD_LO)
                        d = COORD_LO;
                    rg_drop[i] = d[CB-1:0];
                    // speed up, saturating
                    nrate = longint'(rg_rate[i]) + wtr_pkg::FALL_ACCEL * longint'(ft_now);
                    if (nrate > RATE_TOP)
                        nrate = RATE_TOP;
                    rg_rate[i] = nrate[wtr_pkg::RATE_BITS-1:0];
                    // goal reached: region goes away
                    if (d <= longint'(rg_goal[i]))
                    begin
                        rg_drop[i]  = rg_goal[i];
                        rg_live[i]  = 1'b0;
                        rg_drain[i] = 1'b0;
                        a.refresh   = 1'b1;
                    end
                end
            end
            wtr_pkg::OP_QUERY3, wtr_pkg::OP_QUERY2:
            begin
                px = longint'(pos_x);
                py = longint'(pos_y);
                pz = longint'(pos_z);
                r  = longint'(radius);
                for (i = 0; i < REGIONS; i++)
                begin
                    if (!rg_live[i])
                        continue;
                    lv = longint'(rg_top[i]) + longint'(rg_drop[i]);
                    if (op == wtr_pkg::OP_QUERY3 && py > lv - wtr_pkg::HEIGHT_MARGIN)
                        continue;
                    if (!axis_overlaps(px - r, px + r, rg_lo_x[i], rg_hi_x[i]))
                        continue;
                    if (!axis_overlaps(pz - r, pz + r, rg_lo_z[i], rg_hi_z[i]))
                        continue;
                    a.hit   = 1'b1;
                    a.slot  = SB'(i);
                    a.level = lv[CB:0];
                    break;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic field_check(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fails++;
        end
    endtask

    // result check, word acceptance and register writes, all on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                got.hit      = hit;
                got.slot     = hit_slot;
                got.level    = water_level;
                got.refresh  = refresh;
                got.rejected = rejected;
                if (answers_due.size() == 0)
                begin
                    $error("result word with nothing pending");
                    fails++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    field_check("hit", 32'(want.hit), 32'(got.hit));
                    field_check("hit_slot", 32'(want.slot), 32'(got.slot));
                    field_check("water_level", 32'($signed(want.level)),
                                32'($signed(got.level)));
                    field_check("refresh", 32'(want.refresh), 32'(got.refresh));
                    field_check("rejected", 32'(want.rejected), 32'(got.rejected));
                end
            end
            if (start && !busy)
            begin
                apply_region_op(ans);
                if (pin_valid)
                    ans = pin_ans;
                answers_due.push_back(ans);
                words_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                ft_now = cfg_data;
                cfg_taken++;
            end
        end
    end

    // word builders for the directed script
    function automatic word_t add_word(logic signed [CB-1:0] lx, logic signed [CB-1:0] hx,
                                       logic signed [CB-1:0] lz, logic signed [CB-1:0] hz,
                                       logic signed [CB-1:0] ty);
        word_t w;
        w = '0;
        w.op    = wtr_pkg::OP_ADD;
        w.min_x = lx;
        w.max_x = hx;
        w.min_z = lz;
        w.max_z = hz;
        w.top_y = ty;
        return w;
    endfunction

    function automatic word_t query_word(logic [2:0] kind, logic signed [CB-1:0] x,
                                         logic signed [CB-1:0] y, logic signed [CB-1:0] z,
                                         logic [CB-2:0] rad);
        word_t w;
        w = '0;
        w.op     = kind;
        w.pos_x  = x;
        w.pos_y  = y;
        w.pos_z  = z;
        w.radius = rad;
        return w;
    endfunction

    function automatic word_t ctl_word(logic [2:0] kind, logic [SB-1:0] s,
                                       logic signed [CB-1:0] g);
        word_t w;
        w = '0;
        w.op        = kind;
        w.slot      = s;
        w.goal_drop = g;
        return w;
    endfunction

    function automatic word_t pinned(word_t w, region_answer_t a);
        w.pinned = 1'b1;
        w.want   = a;
        return w;
    endfunction

    function automatic region_answer_t added_at(int s);
        region_answer_t a;
        a = '0;
        a.slot = SB'(s);
        return a;
    endfunction

    function automatic longint near(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic longint between(longint a, longint b);
        longint t;
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        return a + longint'($urandom_range(0, 32'(b - a)));
    endfunction

    function automatic logic signed [CB-1:0] fit_coord(longint v);
        if (v > COORD_HI)
            v = COORD_HI;
        if (v < COORD_LO)
            v = COORD_LO;
        return v[CB-1:0];
    endfunction

    // random word; drains and queries aimed at live regions most of the time
    task automatic pick_word(input int tick_pct, output word_t w);
        int     i;
        int     roll;
        int     s;
        int     picks [$];
        longint lo;
        longint lv;
        w = '0;
        roll = $urandom_range(0, 99);
        if (roll < 18)
        begin
            w.op = wtr_pkg::OP_ADD;
            if ($urandom_range(0, 9) == 0)
            begin
                w.min_x = CB'($urandom);
                w.max_x = CB'($urandom);
                w.min_z = CB'($urandom);
                w.max_z = CB'($urandom);
                w.top_y = CB'($urandom);
            end
            else
            begin
                lo = near(4096);
                w.min_x = CB'(lo);
                w.max_x = CB'(lo + longint'($urandom_range(0, 2048)));
                lo = near(4096);
                w.min_z = CB'(lo);
                w.max_z = CB'(lo + longint'($urandom_range(0, 2048)));
                w.top_y = CB'(near(2048));
                // now and then min_x from max_x and max_x from the low z bound, which can invert the box
                if ($urandom_range(0, 9) == 0)
                begin
                    w.min_x = w.max_x;
                    w.max_x = CB'(lo);
                end
            end
        end
        else if (roll < 32)
        begin
            w.op = wtr_pkg::OP_DRAIN;
            for (i = 0; i < REGIONS; i++)
                if (rg_live[i] && !rg_drain[i])
                    picks.push_back(i);
            if (picks.size() > 0 && $urandom_range(0, 4) != 0)
                w.slot = SB'(picks[$urandom_range(0, picks.size() - 1)]);
            else
                w.slot = SB'($urandom_range(0, REGIONS - 1));
            roll = $urandom_range(0, 99);
            if (roll < 55)
                w.goal_drop = CB'(-longint'($urandom_range(0, 512)));
            else if (roll < 80)
                w.goal_drop = CB'(-longint'($urandom_range(0, 65536)));
            else if (roll < 95)
                w.goal_drop = CB'(-longint'($urandom_range(0, 8388608)));
            else if (roll < 98)
                w.goal_drop = C_MIN;
            else
                w.goal_drop = '0;
        end
        else if (roll < 32 + tick_pct)
        begin
            w.op   = wtr_pkg::OP_TICK;
            w.slot = SB'($urandom_range(0, REGIONS - 1));
        end
        else if (roll < 97)
        begin
            w.op = ($urandom_range(0, 1) != 0) ? wtr_pkg::OP_QUERY3 : wtr_pkg::OP_QUERY2;
            for (i = 0; i < REGIONS; i++)
                if (rg_live[i])
                    picks.push_back(i);
            if (picks.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                s = picks[$urandom_range(0, picks.size() - 1)];
                w.pos_x = CB'(between(rg_lo_x[s], rg_hi_x[s]));
                w.pos_z = CB'(between(rg_lo_z[s], rg_hi_z[s]));
                lv = longint'(rg_top[s]) + longint'(rg_drop[s]);
                // half the time right at the height margin
                if ($urandom_range(0, 1) != 0)
                    w.pos_y = fit_coord(lv - wtr_pkg::HEIGHT_MARGIN + near(2));
                else
                    w.pos_y = fit_coord(lv + near(4096));
            end
            else if ($urandom_range(0, 1) != 0)
            begin
                w.pos_x = CB'(near(8192));
                w.pos_y = CB'(near(8192));
                w.pos_z = CB'(near(8192));
            end
            else
            begin
                w.pos_x = CB'($urandom);
                w.pos_y = CB'($urandom);
                w.pos_z = CB'($urandom);
            end
            if ($urandom_range(0, 4) != 0)
                w.radius = (CB-1)'($urandom_range(0, 256));
            else
                w.radius = (CB-1)'($urandom);
        end
        else
        begin
            // ignored codes with noise on every field
            w.op        = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            w.slot      = SB'($urandom);
            w.min_x     = CB'($urandom);
            w.max_x     = CB'($urandom);
            w.min_z     = CB'($urandom);
            w.max_z     = CB'($urandom);
            w.top_y     = CB'($urandom);
            w.goal_drop = CB'(-longint'($urandom_range(0, 8388608)));
            w.pos_x     = CB'($urandom);
            w.pos_y     = CB'($urandom);
            w.pos_z     = CB'($urandom);
            w.radius    = (CB-1)'($urandom);
        end
    endtask

    // drive one word at the falling edge and hold it until taken
    task automatic send_word(input word_t w);
        int seen;
        op        = w.op;
        slot      = w.slot;
        min_x     = w.min_x;
        max_x     = w.max_x;
        min_z     = w.min_z;
        max_z     = w.max_z;
        top_y     = w.top_y;
        goal_drop = w.goal_drop;
        pos_x     = w.pos_x;
        pos_y     = w.pos_y;
        pos_z     = w.pos_z;
        radius    = w.radius;
        pin_valid = w.pinned;
        pin_ans   = w.want;
        start     = 1'b1;
        seen      = words_taken;
        do
        begin
            @(negedge clk);
        end
        while (words_taken == seen);
    endtask

    // hold off until every pending result word is back
    task automatic settle();
        start = 1'b0;
        while (answers_due.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic set_frame_time(input logic [FB-1:0] v);
        int seen;
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data  = v;
        cfg_valid = 1'b1;
        seen      = cfg_taken;
        do
        begin
            @(negedge clk);
        end
        while (cfg_taken == seen);
        cfg_valid = 1'b0;
    endtask

    task automatic build_script();
        // empty table, ignored codes and refused drains
        script.push_back(pinned(query_word(wtr_pkg::OP_QUERY3, 0, 0, 0, 0), QUIET));
        script.push_back(pinned(query_word(wtr_pkg::OP_QUERY2, C_MAX, C_MIN, C_MIN, R_MAX),
                                QUIET));
        script.push_back(pinned(ctl_word(wtr_pkg::OP_TICK, 0, 0), QUIET));
        script.push_back(pinned(ctl_word(wtr_pkg::OP_DRAIN, 0, 0), REFUSED));
        script.push_back(pinned(ctl_word(wtr_pkg::OP_DRAIN, 15, C_MIN), REFUSED));
        script.push_back(pinned(ctl_word(OP_UNUSED_FIRST, 15, C_MIN), QUIET));
        script.push_back(pinned(ctl_word(OP_UNUSED_LAST, 0, 0), QUIET));
        // full-range box, small box, inverted box, lowest surface
        script.push_back(pinned(add_word(C_MIN, C_MAX, C_MIN, C_MAX, C_MAX), added_at(0)));
        script.push_back(pinned(add_word(0, 1024, -1024, 0, 0), added_at(1)));
        script.push_back(pinned(add_word(1024, -1024, 512, -512, -256), added_at(2)));
        script.push_back(pinned(add_word(-256, 256, -256, 256, C_MIN), added_at(3)));
        // height margin edges and widest sphere
        script.push_back(query_word(wtr_pkg::OP_QUERY3, 512, -768, -512, 0));
        script.push_back(query_word(wtr_pkg::OP_QUERY3, 0, CB'(C_MAX - 768), 0, 0));
        script.push_back(query_word(wtr_pkg::OP_QUERY3, 0, CB'(C_MAX - 767), 0, 0));
        script.push_back(query_word(wtr_pkg::OP_QUERY2, C_MIN, 0, C_MIN, R_MAX));
        // draining, double start, zero goal removed on first tick
        script.push_back(ctl_word(wtr_pkg::OP_DRAIN, 0, C_MIN));
        script.push_back(pinned(ctl_word(wtr_pkg::OP_DRAIN, 0, 0), REFUSED));
        script.push_back(ctl_word(wtr_pkg::OP_DRAIN, 1, 0));
        script.push_back(ctl_word(wtr_pkg::OP_TICK, 0, 0));
        script.push_back(query_word(wtr_pkg::OP_QUERY2, 0, 0, -512, 0));
        script.push_back(pinned(ctl_word(wtr_pkg::OP_DRAIN, 1, 0), REFUSED));
        script.push_back(ctl_word(wtr_pkg::OP_TICK, 0, 0));
        script.push_back(add_word(-8, 8, -8, 8, 1000));
        script.push_back(query_word(wtr_pkg::OP_QUERY3, 0, 0, 0, 0));
    endtask

    // main sequence
    initial
    begin
        word_t              w;
        int                 ph;
        int                 k;
        int                 idle_pct;
        logic [FB-1:0]      ft_pick;

        rst_n       = 1'b0;
        start       = 1'b0;
        op          = '0;
        slot        = '0;
        min_x       = '0;
        max_x       = '0;
        min_z       = '0;
        max_z       = '0;
        top_y       = '0;
        goal_drop   = '0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        radius      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        pin_valid   = 1'b0;
        pin_ans     = '0;
        words_taken = 0;
        cfg_taken   = 0;
        fails       = 0;
        ft_now      = wtr_pkg::FT_RESET;
        for (k = 0; k < REGIONS; k++)
        begin
            rg_live[k]  = 1'b0;
            rg_drain[k] = 1'b0;
            rg_lo_x[k]  = '0;
            rg_hi_x[k]  = '0;
            rg_lo_z[k]  = '0;
            rg_hi_z[k]  = '0;
            rg_top[k]   = '0;
            rg_drop[k]  = '0;
            rg_goal[k]  = '0;
            rg_rate[k]  = '0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed words back to back
        build_script();
        foreach (script[k])
            send_word(script[k]);

        // random phases: frame time and sender idling change per phase
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin ft_pick = wtr_pkg::FT_RESET;   idle_pct = 0;  end
                1: begin ft_pick = 16'd1;               idle_pct = 65; end
                2: begin ft_pick = '1;                  idle_pct = 33; end
                3: begin ft_pick = '0;                  idle_pct = 0;  end
                default: begin ft_pick = FB'($urandom_range(2, 65534)); idle_pct = 65; end
            endcase
            set_frame_time(ft_pick);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // large frame time: more ticks so drains reach rate saturation
                pick_word((ph == 2) ? 40 : 25, w);
                send_word(w);
                while ($urandom_range(0, 99) < idle_pct)
                begin
                    start = 1'b0;
                    @(negedge clk);
                end
                if ($urandom_range(0, 99) == 0)
                    settle();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fails == 0)
            $display("water_region_table: match");
        else
            $display("water_region_table: mismatch");
        $finish;
    end

endmodule
